FILE: rtl/window_peak_to_peak_meter_top_defines.svh
// Assertion macros used by the back end of the window peak-to-peak meter RTL.
`ifndef WINDOW_PEAK_TO_PEAK_METER_TOP_DEFINES_SVH
`define WINDOW_PEAK_TO_PEAK_METER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WPPM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define WPPM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/wppm_pkg.sv
// Shared types and constants of the window peak-to-peak meter.
package wppm_pkg;

    localparam int DEF_DEPTH       = 64;
    localparam int DEF_SAMPLE_BITS = 12;
    localparam int QUEUE_DEPTH     = 4;

    localparam int SAMPLE_W  = 12;
    localparam int SPAN_W    = 12;
    localparam int LEVEL_W   = 8;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_HIGH = 1'b1;

    localparam logic [CFG_W-1:0] OUT_LOW_RST  = 8'd30;
    localparam logic [CFG_W-1:0] OUT_HIGH_RST = 8'd100;

    localparam logic ACT_STORE = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    localparam int CMD_KIND_W = 2;

    typedef enum logic [CMD_KIND_W-1:0] {
        CMD_STORE = 2'd0,
        CMD_EMPTY = 2'd1,
        CMD_SCAN  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        logic                action;
        logic [SAMPLE_W-1:0] sample;
    } req_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [SPAN_W-1:0]  span;
        logic               ready_res;
    } res_t;

endpackage

FILE: rtl/wppm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wppm_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/wppm_front.sv
// Front end: accepts requests, tracks the write index and fill flag, issues commands.
module wppm_front import wppm_pkg::*; #(
    parameter int DEPTH       = DEF_DEPTH,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_stall,
    input  req_t                     req,
    input  logic                     q_full,
    output logic                     cmd_push,
    output cmd_kind_t                cmd_kind,
    output logic [$clog2(DEPTH)-1:0] cmd_addr,
    output logic [SAMPLE_BITS-1:0]   cmd_sample
);

    localparam int AW    = $clog2(DEPTH);
    localparam int EXT_W = SAMPLE_BITS + SAMPLE_W;

    logic [AW-1:0]    wr_idx_reg, wr_idx_next;
    logic             full_reg, full_next;
    logic             accept;
    logic             wrap;
    logic [EXT_W-1:0] sample_ext;

    assign req_stall  = q_full;
    assign accept     = req_valid && !q_full;
    assign cmd_push   = accept;
    // Samples are cut or zero-extended to the stored width.
    assign sample_ext = EXT_W'(req.sample);
    assign wrap       = (wr_idx_reg == AW'(DEPTH - 1));

    always_comb
    begin
        wr_idx_next = wr_idx_reg;
        full_next   = full_reg;
        cmd_kind    = CMD_STORE;
        cmd_addr    = wr_idx_reg;
        cmd_sample  = sample_ext[SAMPLE_BITS-1:0];
        if (req.action == ACT_READ)
        begin
            cmd_kind = full_reg ? CMD_SCAN : CMD_EMPTY;
        end
        else if (accept)
        begin
            wr_idx_next = wrap ? '0 : wr_idx_reg + AW'(1);
            if (wrap)
            begin
                full_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= '0;
            full_reg   <= 1'b0;
        end
        else
        begin
            wr_idx_reg <= wr_idx_next;
            full_reg   <= full_next;
        end
    end

endmodule

FILE: rtl/wppm_cmd_fifo.sv
// Short command queue between the front end and the back end.
module wppm_cmd_fifo #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output logic             empty
);

    localparam int PW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

endmodule

FILE: rtl/wppm_back.sv
// Back end: executes stores, scans the ring for min and max, maps the span to a level.
`include "window_peak_to_peak_meter_top_defines.svh"

module wppm_back import wppm_pkg::*; #(
    parameter int DEPTH       = DEF_DEPTH,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            q_empty,
    input  logic [CMD_KIND_W+$clog2(DEPTH)+SAMPLE_BITS-1:0] q_head,
    output logic                                            q_pop,
    input  logic [CFG_W-1:0]                                out_low,
    input  logic [CFG_W-1:0]                                out_high,
    output logic                                            ram_we,
    output logic [$clog2(DEPTH)-1:0]                        ram_waddr,
    output logic [SAMPLE_BITS-1:0]                          ram_wdata,
    output logic [$clog2(DEPTH)-1:0]                        ram_raddr,
    input  logic [SAMPLE_BITS-1:0]                          ram_rdata,
    output logic                                            res_valid,
    input  logic                                            res_stall,
    output res_t                                            res
);

    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = CMD_KIND_W + AW + SAMPLE_BITS;
    localparam int PROD_W = SAMPLE_BITS + CFG_W;
    localparam int EXT_W  = SAMPLE_BITS + SPAN_W;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCAN  = 6'b000010,
        ST_DRAIN = 6'b000100,
        ST_SPAN  = 6'b001000,
        ST_MULT  = 6'b010000,
        ST_DIV   = 6'b100000
    } state_t;

    state_t                 state_reg, state_next;
    logic [AW-1:0]          scan_cnt_reg, scan_cnt_next;
    logic                   rd_vld_reg;
    logic [SAMPLE_BITS-1:0] lo_reg, lo_next;
    logic [SAMPLE_BITS-1:0] hi_reg, hi_next;
    logic [SAMPLE_BITS-1:0] span_reg, span_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic                   res_valid_reg, res_valid_next;
    res_t                   res_reg, res_next;

    cmd_kind_t              head_kind;
    logic [AW-1:0]          head_addr;
    logic [SAMPLE_BITS-1:0] head_sample;
    logic                   res_free;
    logic                   res_load;
    logic                   scan_last;
    logic                   start_scan;
    logic [CFG_W-1:0]       diff;
    logic [PROD_W:0]        quot_sum;
    logic [LEVEL_W-1:0]     quot;
    logic [EXT_W-1:0]       span_ext;

    assign head_kind   = cmd_kind_t'(q_head[CW-1 -: CMD_KIND_W]);
    assign head_addr   = q_head[SAMPLE_BITS +: AW];
    assign head_sample = q_head[SAMPLE_BITS-1:0];

    assign res_free   = !res_valid_reg || !res_stall;
    assign q_pop      = (state_reg == ST_IDLE) && !q_empty
                        && ((head_kind == CMD_STORE) || res_free);
    assign start_scan = q_pop && (head_kind == CMD_SCAN);
    assign scan_last  = (scan_cnt_reg == AW'(DEPTH - 1));

    assign ram_we    = q_pop && (head_kind == CMD_STORE);
    assign ram_waddr = head_addr;
    assign ram_wdata = head_sample;
    assign ram_raddr = scan_cnt_reg;

    // An inverted range maps every span to the low end.
    assign diff = (out_high < out_low) ? '0 : out_high - out_low;

    // Division by the full scale 2^N - 1: exact for products below 2^(2N) - 1.
    assign quot_sum = (PROD_W + 1)'(prod_reg) + (PROD_W + 1)'(prod_reg >> SAMPLE_BITS)
                      + (PROD_W + 1)'(1);
    assign quot     = quot_sum[SAMPLE_BITS +: LEVEL_W];
    assign span_ext = EXT_W'(span_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start_scan)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_SPAN;
            ST_SPAN:  state_next = ST_MULT;
            ST_MULT:  state_next = ST_DIV;
            ST_DIV:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        scan_cnt_next = scan_cnt_reg;
        if (start_scan)
        begin
            scan_cnt_next = '0;
        end
        else if (state_reg == ST_SCAN)
        begin
            scan_cnt_next = scan_last ? '0 : scan_cnt_reg + AW'(1);
        end
    end

    always_comb
    begin
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        span_next = span_reg;
        prod_next = prod_reg;
        if (start_scan)
        begin
            lo_next = '1;
            hi_next = '0;
        end
        else if (rd_vld_reg)
        begin
            if (ram_rdata < lo_reg)
            begin
                lo_next = ram_rdata;
            end
            if (ram_rdata > hi_reg)
            begin
                hi_next = ram_rdata;
            end
        end
        if (state_reg == ST_SPAN)
        begin
            span_next = hi_reg - lo_reg;
        end
        if (state_reg == ST_MULT)
        begin
            prod_next = PROD_W'(span_reg) * PROD_W'(diff);
        end
    end

    always_comb
    begin
        res_load       = 1'b0;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;
        if (q_pop && (head_kind == CMD_EMPTY))
        begin
            res_load           = 1'b1;
            res_next.level     = '0;
            res_next.span      = '0;
            res_next.ready_res = 1'b0;
        end
        else if (state_reg == ST_DIV)
        begin
            res_load           = 1'b1;
            res_next.level     = out_low + quot;
            res_next.span      = span_ext[SPAN_W-1:0];
            res_next.ready_res = 1'b1;
        end
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_cnt_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_cnt_reg  <= scan_cnt_next;
            rd_vld_reg    <= (state_reg == ST_SCAN);
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        span_reg <= span_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `WPPM_ASSERT_IMP(a_load_into_free_slot, clk, rst_n, res_load, (!res_valid_reg || !res_stall))
    `WPPM_ASSERT_IMP(a_write_only_idle, clk, rst_n, ram_we, (state_reg == ST_IDLE))
    `WPPM_ASSERT_IMP(a_read_data_in_scan, clk, rst_n, rd_vld_reg, (state_reg == ST_SCAN || state_reg == ST_DRAIN))
    `WPPM_ASSERT_NXT(a_scan_follows_pop, clk, rst_n, start_scan, (state_reg == ST_SCAN && scan_cnt_reg == '0))

endmodule

FILE: rtl/window_peak_to_peak_meter_top.sv
// Top level of the sliding-window peak-to-peak meter.
// A store is queued on acceptance and written into the ring when the back end pops it.
// A read before the first fill is answered with zeros; a read of a full ring passes the pop,
// a sweep of DEPTH addresses, the last RAM read, then span, multiply and divide. Throughput:
// one store per cycle while the queue has room; during a scan up to four requests queue and
// then the input stalls. Reset clears control state and loads out_low 30, out_high 100.
module window_peak_to_peak_meter_top import wppm_pkg::*; #(
    parameter int DEPTH       = DEF_DEPTH,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // Request channel.
    input  logic                 req_valid,
    output logic                 req_stall,
    input  req_t                 req,
    // Result channel.
    output logic                 res_valid,
    input  logic                 res_stall,
    output res_t                 res,
    // Configuration write port.
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = CMD_KIND_W + AW + SAMPLE_BITS;

    // Level mapping registers. Users must change them only while the meter is idle; unchecked.
    logic [CFG_W-1:0] out_low_reg, out_low_next;
    logic [CFG_W-1:0] out_high_reg, out_high_next;

    // Command path from the front end into the queue and out to the back end.
    logic                   cmd_push;
    cmd_kind_t              cmd_kind;
    logic [AW-1:0]          cmd_addr;
    logic [SAMPLE_BITS-1:0] cmd_sample;
    logic [CW-1:0]          q_din;
    logic [CW-1:0]          q_head;
    logic                   q_full;
    logic                   q_empty;
    logic                   q_pop;

    // Sample ring ports.
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [SAMPLE_BITS-1:0] ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [SAMPLE_BITS-1:0] ram_rdata;

    always_comb
    begin
        out_low_next  = out_low_reg;
        out_high_next = out_high_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_OUT_LOW:  out_low_next  = cfg_wdata;
                CFG_OUT_HIGH: out_high_next = cfg_wdata;
                default:      out_low_next  = out_low_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_low_reg  <= OUT_LOW_RST;
            out_high_reg <= OUT_HIGH_RST;
        end
        else
        begin
            out_low_reg  <= out_low_next;
            out_high_reg <= out_high_next;
        end
    end

    // The front end classifies each request. It owns the write index and the
    // sticky full flag, so a read already knows whether a scan is needed.
    wppm_front #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .q_full     (q_full),
        .cmd_push   (cmd_push),
        .cmd_kind   (cmd_kind),
        .cmd_addr   (cmd_addr),
        .cmd_sample (cmd_sample)
    );

    assign q_din = {cmd_kind, cmd_addr, cmd_sample};

    // The queue lets stores keep arriving while a scan is in progress.
    wppm_cmd_fifo #(
        .WIDTH (CW),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .din   (q_din),
        .full  (q_full),
        .pop   (q_pop),
        .head  (q_head),
        .empty (q_empty)
    );

    // The back end executes commands in order against the sample ring and
    // holds the result in its output register until it is taken.
    wppm_back #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_low   (out_low_reg),
        .out_high  (out_high_reg),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    wppm_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

FILE: verif/window_peak_to_peak_meter_top_test.sv
// Self-checking testbench for the sliding-window peak-to-peak meter.
`timescale 1ns / 100ps

import wppm_pkg::*;

// Scoreboard: keeps its own copy of the sample ring and the output range,
// predicts the reading for every accepted read and checks the block's answers.
class meter_scoreboard;
    logic [SAMPLE_W-1:0] ring [DEF_DEPTH];
    int                  wr_ptr;
    bit                  wrapped;
    logic [CFG_W-1:0]    out_low;
    logic [CFG_W-1:0]    out_high;
    res_t                expected_readings [$];
    int                  errors;

    function new();
        wr_ptr   = 0;
        wrapped  = 1'b0;
        out_low  = OUT_LOW_RST;
        out_high = OUT_HIGH_RST;
        errors   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        if (idx == CFG_OUT_LOW)
            out_low = val;
        else if (idx == CFG_OUT_HIGH)
            out_high = val;
    endfunction

    // Notes an accepted request: a store updates the ring, a read queues a reading.
    function void take_request(req_t item);
        res_t        reading;
        int unsigned full_scale;
        int unsigned lo;
        int unsigned hi;
        int unsigned span;
        full_scale = (1 << DEF_SAMPLE_BITS) - 1;
        if (item.action == ACT_STORE)
        begin
            ring[wr_ptr] = item.sample;
            wr_ptr = (wr_ptr + 1) % DEF_DEPTH;
            if (wr_ptr == 0)
                wrapped = 1'b1;
            return;
        end
        reading = '0;
        // Until the ring has wrapped once the reading is all zero.
        if (wrapped)
        begin
            lo = full_scale;
            hi = 0;
            foreach (ring[i])
            begin
                if (ring[i] < lo)
                    lo = ring[i];
                if (ring[i] > hi)
                    hi = ring[i];
            end
            span = hi - lo;
            reading.span      = span[SPAN_W-1:0];
            reading.ready_res = 1'b1;
            if (out_high < out_low)
                reading.level = out_low;
            else
                reading.level = LEVEL_W'(out_low + span * (out_high - out_low) / full_scale);
        end
        expected_readings.push_back(reading);
    endfunction

    function void report(string field, int want, int got);
        errors++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    function void check_result(res_t got);
        res_t want;
        if (expected_readings.size() == 0)
        begin
            errors++;
            $display("%0t ns: reading with none expected, actual level %0d span %0d ready %0d",
                     $time, got.level, got.span, got.ready_res);
            return;
        end
        want = expected_readings.pop_front();
        if (got.level !== want.level)
            report("level", want.level, got.level);
        if (got.span !== want.span)
            report("span", want.span, got.span);
        if (got.ready_res !== want.ready_res)
            report("ready_res", want.ready_res, got.ready_res);
    endfunction

    function int pending();
        return expected_readings.size();
    endfunction
endclass

module window_peak_to_peak_meter_top_test;

    // A full-ring read answers only after a sweep of the whole ring, and stores can
    // still be queued behind it, so the quiet time before a register write and at
    // the end of the run covers that with some margin.
    localparam int DRAIN_CYCLES = DEF_DEPTH + 40;
    // Length of the one long hold-off on the result side.
    localparam int LONG_HOLD = 600;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_stall;
    req_t                 req;
    logic                 res_valid;
    logic                 res_stall;
    res_t                 res;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_wdata;

    meter_scoreboard meter_sb = new();

    // Percentage chance of an idle burst after each result-side cycle or accepted request.
    // Zero means no idling at all for the current phase.
    int idle_pct;
    // Set by the request side to ask the result side for one long hold-off.
    bit hold_off_req;

    // Current band of sample values: readings over a narrow band give small spans.
    int band_lo;
    int band_width;

    always #10 clk = ~clk;

    window_peak_to_peak_meter_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #16_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Every result taken at a clock edge is checked against the oldest prediction.
    // Both res_valid and res_stall are read before this edge's updates land.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            meter_sb.check_result(res);
    end

    // Result side: random stall bursts, plus one long hold-off on request so
    // that the command queue fills and the block has to stall its request input.
    initial
    begin
        res_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                res_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                res_stall <= 1'b0;
            end
            else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    // Offers one request and holds it until the block takes it. The request is
    // noted in the scoreboard at the edge where it is accepted. An idle burst
    // may follow; otherwise valid stays high for the next request.
    task automatic send(input logic act, input logic [SAMPLE_W-1:0] smp);
        req_t item;
        item.action = act;
        item.sample = smp;
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        meter_sb.take_request(item);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Stops sending, waits for every predicted reading, then lets any stores
    // still queued in the block settle so that it is truly idle.
    task automatic drain();
        req_valid <= 1'b0;
        while (meter_sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes the low range register, then the high range register.
    task automatic set_range(input logic [CFG_W-1:0] low, input logic [CFG_W-1:0] high);
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_OUT_LOW;
        cfg_wdata <= low;
        @(posedge clk);
        meter_sb.write_reg(CFG_OUT_LOW, low);
        cfg_idx   <= CFG_OUT_HIGH;
        cfg_wdata <= high;
        @(posedge clk);
        meter_sb.write_reg(CFG_OUT_HIGH, high);
        cfg_we <= 1'b0;
    endtask

    // Chooses a new band: constant, two values, narrow, wide or full scale.
    task automatic pick_band();
        case ($urandom_range(0, 4))
            0:       band_width = 0;
            1:       band_width = 1;
            2:       band_width = $urandom_range(2, 64);
            3:       band_width = $urandom_range(65, SAMPLE_MAX - 1);
            default: band_width = SAMPLE_MAX;
        endcase
        band_lo = $urandom_range(0, SAMPLE_MAX - band_width);
    endtask

    function automatic logic [SAMPLE_W-1:0] next_sample();
        return SAMPLE_W'(band_lo + $urandom_range(0, band_width));
    endfunction

    // Random traffic: stores drawn from bands that change every 16 to 160
    // requests, so that the window sees many different spans, mixed with
    // reads at the given rate.
    task automatic run_phase(input int count, input int read_pct);
        int band_left;
        band_left = 0;
        repeat (count)
        begin
            if (band_left == 0)
            begin
                pick_band();
                band_left = $urandom_range(16, 160);
            end
            band_left--;
            if ($urandom_range(0, 99) < read_pct)
                send(ACT_READ, next_sample());
            else
                send(ACT_STORE, next_sample());
        end
    endtask

    initial
    begin
        int low;
        int high;
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        cfg_we       = 1'b0;
        cfg_idx      = CFG_OUT_LOW;
        cfg_wdata    = '0;
        idle_pct     = 0;
        hold_off_req = 1'b0;
        band_lo      = 0;
        band_width   = SAMPLE_MAX;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, at reset range. Reads before the first wrap report not
        // ready and must not depend on the unwritten ring.
        send(ACT_READ, SAMPLE_MAX);
        send(ACT_STORE, '0);
        send(ACT_STORE, SAMPLE_MAX);
        send(ACT_READ, '0);
        // Complete the first fill: the window now spans the whole scale.
        repeat (DEF_DEPTH - 2) send(ACT_STORE, 12'd2048);
        send(ACT_READ, 12'h555);
        // A constant window gives zero span and the low end of the range.
        repeat (DEF_DEPTH) send(ACT_STORE, 12'd1234);
        send(ACT_READ, 12'haaa);
        // Bring both extremes back into the window.
        send(ACT_STORE, '0);
        send(ACT_STORE, SAMPLE_MAX);
        // Full-scale span under an inverted, the widest, an empty and a top range.
        drain();
        set_range(8'd255, 8'd0);
        send(ACT_READ, '0);
        drain();
        set_range(8'd0, 8'd255);
        send(ACT_READ, '0);
        drain();
        set_range(8'd0, 8'd0);
        send(ACT_READ, '0);
        drain();
        set_range(8'd255, 8'd255);
        send(ACT_READ, '0);

        // Random phases, each under its own range setting and idling rate.
        for (int phase = 0; phase < 8; phase++)
        begin
            drain();
            case (phase)
                0:
                begin
                    low  = OUT_LOW_RST;
                    high = OUT_HIGH_RST;
                end
                1:
                begin
                    low  = 0;
                    high = 255;
                end
                2:
                begin
                    low  = 200;
                    high = 17;
                end
                default:
                begin
                    low  = $urandom_range(0, 255);
                    high = $urandom_range(0, 255);
                end
            endcase
            set_range(CFG_W'(low), CFG_W'(high));
            case ($urandom_range(0, 2))
                0:       idle_pct = 0;
                1:       idle_pct = 10;
                default: idle_pct = 35;
            endcase
            if (phase == 4)
            begin
                // Read-heavy traffic against a long result hold-off.
                hold_off_req = 1'b1;
                run_phase(200, 60);
            end
            else if (phase == 7)
            begin
                // Closing stretch at full rate on both sides.
                idle_pct = 0;
                run_phase(200, 12);
            end
            else
            begin
                run_phase(200, 12);
            end
        end

        drain();
        if (meter_sb.errors == 0 && meter_sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/wppm_pkg.sv
rtl/wppm_ram.sv
rtl/wppm_front.sv
rtl/wppm_cmd_fifo.sv
rtl/wppm_back.sv
rtl/window_peak_to_peak_meter_top.sv
verif/window_peak_to_peak_meter_top_test.sv
